// ===== hdl/kml_pkg.sv =====
// ----------------------------------------------------------------------------
// kml_pkg
// Types, codes and sizes shared by the k-means clusterer modules.
// ----------------------------------------------------------------------------
package kml_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIM      = 4;
  localparam int COORD_W      = 16;
  localparam int PT_AW        = 10;  // point store address bits
  localparam int CNT_W        = 11;  // point and cluster member counts
  localparam int CL_W         = 3;   // cluster index bits
  localparam int DIM_W        = 2;   // coordinate index bits
  localparam int SUM_W        = 26;  // per-cluster coordinate sums
  localparam int SQ_W         = 32;  // one squared difference
  localparam int ACC_W        = 38;  // summed squared differences
  localparam int THR_W        = 36;
  localparam int CFG_AW       = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_POINT    = 2'd0,
    ACT_LOAD_CENTROID = 2'd1,
    ACT_TRAIN         = 2'd2,
    ACT_CLASSIFY      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_CENTROID = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_DIMENSIONS   = 2'd1,
    CFG_MAX_ITER     = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic [CL_W-1:0]           slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [CL_W-1:0]           cluster_index;
    logic signed [COORD_W-1:0] out_coord_0;
    logic signed [COORD_W-1:0] out_coord_1;
    logic signed [COORD_W-1:0] out_coord_2;
    logic signed [COORD_W-1:0] out_coord_3;
    logic                      converged;
    logic [7:0]                passes_done;
    logic                      points_dropped;
    logic                      last;
  } out_word_t;

endpackage

// ===== hdl/kml_sqdiff.sv =====
// ----------------------------------------------------------------------------
// kml_sqdiff
// Shared squared-difference unit with a running accumulator.
// ----------------------------------------------------------------------------
module kml_sqdiff (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [kml_pkg::COORD_W-1:0] a_i,
  input  logic signed [kml_pkg::COORD_W-1:0] b_i,
  input  logic                              en_i,
  input  logic                              first_i,
  output logic [kml_pkg::SQ_W-1:0]          sq_o,
  output logic [kml_pkg::ACC_W-1:0]         sum_o
);

  logic signed [kml_pkg::COORD_W:0]     diff;
  logic signed [2*kml_pkg::COORD_W+1:0] prod;
  logic [kml_pkg::ACC_W-1:0]            acc_q;

  assign diff  = {a_i[kml_pkg::COORD_W-1], a_i} - {b_i[kml_pkg::COORD_W-1], b_i};
  assign prod  = diff * diff;
  assign sq_o  = prod[kml_pkg::SQ_W-1:0];
  assign sum_o = (first_i ? '0 : acc_q) + kml_pkg::ACC_W'(sq_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= sum_o;
    end
  end

endmodule

// ===== hdl/kml_div.sv =====
// ----------------------------------------------------------------------------
// kml_div
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kml_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [kml_pkg::SUM_W-1:0]   dividend_i,
  input  logic [kml_pkg::CNT_W-1:0]          divisor_i,
  output logic                               done_o,
  output logic signed [kml_pkg::COORD_W-1:0] quot_o
);

  logic                        busy_q, done_q, neg_q;
  logic [4:0]                  cnt_q;
  logic [kml_pkg::SUM_W-1:0]   work_q;
  logic [kml_pkg::CNT_W-1:0]   rem_q, dvs_q;
  logic [kml_pkg::CNT_W:0]     shifted;
  logic [kml_pkg::CNT_W+1:0]   trial;

  assign shifted = {rem_q, work_q[kml_pkg::SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = neg_q ? -work_q[kml_pkg::COORD_W-1:0] : work_q[kml_pkg::COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        neg_q  <= dividend_i[kml_pkg::SUM_W-1];
        work_q <= dividend_i[kml_pkg::SUM_W-1] ? -dividend_i : dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // keep the trial remainder when it did not borrow
        if (!trial[kml_pkg::CNT_W+1]) begin
          rem_q  <= trial[kml_pkg::CNT_W-1:0];
          work_q <= {work_q[kml_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_q  <= shifted[kml_pkg::CNT_W-1:0];
          work_q <= {work_q[kml_pkg::SUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(kml_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/kmeans_lloyd_clusterer.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_clusterer
// Lloyd k-means over Q8.8 vectors with a shared squared-difference unit.
// ----------------------------------------------------------------------------
// Input words carry an action: load point, load initial centroid, train, or
// classify. Loads give no result. A classify word gives one result word, its
// distances measured one coordinate at a time in the squared-difference unit.
// Training runs passes of assignment over the stored points plus an update of
// each used coordinate of each non-empty cluster through the division unit
// (one quotient bit a cycle) and the one squared-difference unit. After
// the last pass k centroid words and one status word follow, the status word
// marked last. in_ready_o is high only while no request is in progress.
// Result words sit in an output register; when the receiver stalls the block
// holds in its emit step until the word is taken. Reset clears the point
// count, the overflow flag, the centroids and the registers to their
// defaults; no clearing pass is needed. Configuration writes are always
// taken (cfg_ready_o high) and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clusterer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  kml_pkg::in_word_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output kml_pkg::out_word_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kml_pkg::CFG_AW-1:0]         cfg_index_i,
  input  logic [kml_pkg::THR_W-1:0]          cfg_data_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PASS   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_DIST   = 10'b0000001000,
    S_ASSIGN = 10'b0000010000,
    S_UPD    = 10'b0000100000,
    S_DIVW   = 10'b0001000000,
    S_PEND   = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_CLS    = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [3:0]                 ncl_q;
  logic [2:0]                 dim_q;
  logic [7:0]                 maxit_q;
  logic [kml_pkg::THR_W-1:0]  thr_q;

  logic [3:0] kc;
  logic [2:0] dc;
  logic [7:0] limit;
  logic [kml_pkg::CL_W-1:0]  kc_last;
  logic [kml_pkg::DIM_W-1:0] dc_last;

  logic [kml_pkg::CNT_W-1:0]  cnt_q, pt_q;
  logic                       ovf_q, cls_q, conv_q, stat_q;
  logic [kml_pkg::CL_W-1:0]   c_q, best_q;
  logic [kml_pkg::DIM_W-1:0]  j_q;
  logic [kml_pkg::ACC_W-1:0]  bestd_q, chg_q;
  logic [7:0]                 pass_q;

  logic signed [kml_pkg::COORD_W-1:0] cent_q [kml_pkg::MAX_CLUSTERS][kml_pkg::MAX_DIM];
  logic signed [kml_pkg::SUM_W-1:0]   sum_q  [kml_pkg::MAX_CLUSTERS][kml_pkg::MAX_DIM];
  logic [kml_pkg::CNT_W-1:0]          ccnt_q [kml_pkg::MAX_CLUSTERS];
  logic signed [kml_pkg::COORD_W-1:0] p_q    [kml_pkg::MAX_DIM];
  logic signed [kml_pkg::COORD_W-1:0] pv     [kml_pkg::MAX_DIM];
  logic signed [kml_pkg::COORD_W-1:0] in_c   [kml_pkg::MAX_DIM];

  logic [kml_pkg::MAX_DIM*kml_pkg::COORD_W-1:0] pstore [kml_pkg::MAX_POINTS];
  logic [kml_pkg::MAX_DIM*kml_pkg::COORD_W-1:0] rd_word_q;

  logic                out_valid_q, out_free, in_fire, store_we;
  kml_pkg::out_word_t  out_q;
  logic                emit_fire;
  kml_pkg::out_word_t  emit_word;

  logic signed [kml_pkg::COORD_W-1:0] ua, ub;
  logic                               u_en, u_first;
  logic [kml_pkg::SQ_W-1:0]           u_sq;
  logic [kml_pkg::ACC_W-1:0]          u_sum;

  logic                               div_start, div_done;
  logic signed [kml_pkg::COORD_W-1:0] div_q;
  logic [7:0]                         pass_next;

  // clamped configuration
  always_comb begin
    if (ncl_q < 4'd2) begin
      kc = 4'd2;
    end else if (ncl_q > 4'(kml_pkg::MAX_CLUSTERS)) begin
      kc = 4'(kml_pkg::MAX_CLUSTERS);
    end else begin
      kc = ncl_q;
    end
    if (dim_q < 3'd1) begin
      dc = 3'd1;
    end else if (dim_q > 3'(kml_pkg::MAX_DIM)) begin
      dc = 3'(kml_pkg::MAX_DIM);
    end else begin
      dc = dim_q;
    end
  end

  assign limit   = (maxit_q == 8'd0) ? 8'd1 : maxit_q;
  assign kc_last = 3'(kc - 4'd1);
  assign dc_last = 2'(dc - 3'd1);

  assign in_c[0] = in_data_i.coord_0;
  assign in_c[1] = in_data_i.coord_1;
  assign in_c[2] = in_data_i.coord_2;
  assign in_c[3] = in_data_i.coord_3;

  always_comb begin
    for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
      pv[j] = cls_q ? p_q[j] : rd_word_q[j*kml_pkg::COORD_W +: kml_pkg::COORD_W];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign store_we    = in_fire && (in_data_i.action == kml_pkg::ACT_LOAD_POINT) &&
                       (cnt_q < kml_pkg::CNT_W'(kml_pkg::MAX_POINTS));
  assign pass_next   = pass_q + 8'd1;
  assign emit_fire   = out_free && ((state_q == S_EMIT) || (state_q == S_CLS));

  // result word for the emit and classify steps
  always_comb begin
    emit_word = '0;
    if (state_q == S_CLS) begin
      emit_word.kind          = kml_pkg::KIND_CLASSIFY;
      emit_word.cluster_index = best_q;
      emit_word.last          = 1'b1;
    end else if (stat_q) begin
      emit_word.kind           = kml_pkg::KIND_STATUS;
      emit_word.converged      = conv_q;
      emit_word.passes_done    = pass_q;
      emit_word.points_dropped = ovf_q;
      emit_word.last           = 1'b1;
    end else begin
      emit_word.kind          = kml_pkg::KIND_CENTROID;
      emit_word.cluster_index = c_q;
      emit_word.out_coord_0   = cent_q[c_q][0];
      emit_word.out_coord_1   = (dc > 3'd1) ? cent_q[c_q][1] : '0;
      emit_word.out_coord_2   = (dc > 3'd2) ? cent_q[c_q][2] : '0;
      emit_word.out_coord_3   = (dc > 3'd3) ? cent_q[c_q][3] : '0;
    end
  end

  // the unit measures distance, or the centroid move once a mean is ready
  assign ua      = (state_q == S_DIVW) ? div_q : cent_q[c_q][j_q];
  assign ub      = (state_q == S_DIVW) ? cent_q[c_q][j_q] : pv[j_q];
  assign u_en    = (state_q == S_DIST);
  assign u_first = (j_q == '0);

  assign div_start = (state_q == S_UPD) && (ccnt_q[c_q] != '0);

  kml_sqdiff u_sqdiff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .a_i     (ua),
    .b_i     (ub),
    .en_i    (u_en),
    .first_i (u_first),
    .sq_o    (u_sq),
    .sum_o   (u_sum)
  );

  kml_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[c_q][j_q]),
    .divisor_i  (ccnt_q[c_q]),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // point store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      pstore[cnt_q[kml_pkg::PT_AW-1:0]] <= {in_c[3], in_c[2], in_c[1], in_c[0]};
    end
    if (state_q == S_RD) begin
      rd_word_q <= pstore[pt_q[kml_pkg::PT_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ncl_q       <= 4'd2;
      dim_q       <= 3'd4;
      maxit_q     <= 8'd101;
      thr_q       <= 36'd7;
      cnt_q       <= '0;
      pt_q        <= '0;
      ovf_q       <= 1'b0;
      cls_q       <= 1'b0;
      conv_q      <= 1'b0;
      stat_q      <= 1'b0;
      c_q         <= '0;
      best_q      <= '0;
      j_q         <= '0;
      bestd_q     <= '0;
      chg_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int c = 0; c < kml_pkg::MAX_CLUSTERS; c++) begin
        ccnt_q[c] <= '0;
        for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
          cent_q[c][j] <= '0;
          sum_q[c][j]  <= '0;
        end
      end
      for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
        p_q[j] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kml_pkg::CFG_NUM_CLUSTERS: ncl_q   <= cfg_data_i[3:0];
          kml_pkg::CFG_DIMENSIONS:   dim_q   <= cfg_data_i[2:0];
          kml_pkg::CFG_MAX_ITER:     maxit_q <= cfg_data_i[7:0];
          kml_pkg::CFG_THRESHOLD:    thr_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_word;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data_i.action)
              kml_pkg::ACT_LOAD_POINT: begin
                if (store_we) begin
                  cnt_q <= cnt_q + 1'b1;
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              kml_pkg::ACT_LOAD_CENTROID: begin
                if (4'(in_data_i.slot) < 4'(kml_pkg::MAX_CLUSTERS)) begin
                  for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
                    cent_q[in_data_i.slot][j] <= in_c[j];
                  end
                end
              end
              kml_pkg::ACT_TRAIN: begin
                cls_q   <= 1'b0;
                conv_q  <= 1'b0;
                pass_q  <= '0;
                state_q <= S_PASS;
              end
              default: begin
                for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
                  p_q[j] <= in_c[j];
                end
                cls_q   <= 1'b1;
                c_q     <= '0;
                j_q     <= '0;
                state_q <= S_DIST;
              end
            endcase
          end
        end

        S_PASS: begin
          for (int c = 0; c < kml_pkg::MAX_CLUSTERS; c++) begin
            ccnt_q[c] <= '0;
            for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
              sum_q[c][j] <= '0;
            end
          end
          chg_q   <= '0;
          pt_q    <= '0;
          c_q     <= '0;
          j_q     <= '0;
          state_q <= (cnt_q == '0) ? S_UPD : S_RD;
        end

        S_RD: begin
          c_q     <= '0;
          j_q     <= '0;
          state_q <= S_DIST;
        end

        S_DIST: begin
          if (j_q == dc_last) begin
            // strict compare keeps the lower index on a tie
            if (c_q == '0 || u_sum < bestd_q) begin
              bestd_q <= u_sum;
              best_q  <= c_q;
            end
            if (c_q == kc_last) begin
              state_q <= cls_q ? S_CLS : S_ASSIGN;
            end else begin
              c_q <= c_q + 1'b1;
              j_q <= '0;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end

        S_ASSIGN: begin
          for (int j = 0; j < kml_pkg::MAX_DIM; j++) begin
            if (3'(j) < dc) begin
              sum_q[best_q][j] <= sum_q[best_q][j] + kml_pkg::SUM_W'(pv[j]);
            end
          end
          ccnt_q[best_q] <= ccnt_q[best_q] + 1'b1;
          if (pt_q == cnt_q - 1'b1) begin
            c_q     <= '0;
            j_q     <= '0;
            state_q <= S_UPD;
          end else begin
            pt_q    <= pt_q + 1'b1;
            state_q <= S_RD;
          end
        end

        S_UPD: begin
          if (ccnt_q[c_q] == '0) begin
            // empty cluster keeps its centroid
            j_q <= '0;
            if (c_q == kc_last) begin
              state_q <= S_PEND;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end else begin
            state_q <= S_DIVW;
          end
        end

        S_DIVW: begin
          if (div_done) begin
            chg_q             <= chg_q + kml_pkg::ACC_W'(u_sq);
            cent_q[c_q][j_q]  <= div_q;
            if (j_q == dc_last) begin
              j_q <= '0;
              if (c_q == kc_last) begin
                state_q <= S_PEND;
              end else begin
                c_q     <= c_q + 1'b1;
                state_q <= S_UPD;
              end
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_UPD;
            end
          end
        end

        S_PEND: begin
          pass_q <= pass_next;
          c_q    <= '0;
          stat_q <= 1'b0;
          if (chg_q < kml_pkg::ACC_W'(thr_q)) begin
            conv_q  <= 1'b1;
            state_q <= S_EMIT;
          end else if (pass_next >= limit) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_PASS;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            if (stat_q) begin
              state_q <= S_IDLE;
            end else if (c_q == kc_last) begin
              stat_q <= 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end

        S_CLS: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= kml_pkg::CNT_W'(kml_pkg::MAX_POINTS))
    else $error("point count beyond store capacity");

  a_full_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action == kml_pkg::ACT_LOAD_POINT &&
     cnt_q == kml_pkg::CNT_W'(kml_pkg::MAX_POINTS)) |=> ovf_q)
    else $error("dropped point did not raise the overflow flag");

  a_status_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == kml_pkg::KIND_STATUS) |-> (out_q.passes_done != 8'd0))
    else $error("status word reports zero passes");

  a_assign_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASSIGN) |-> (4'(best_q) < kc))
    else $error("point assigned to a cluster not in use");

endmodule

// ===== sim/tb_kmeans_lloyd_clusterer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmeans_lloyd_clusterer
// Drives point, centroid, train and classify words through the clusterer
// under random gaps, stalls and register settings. A scoreboard predicts
// every result word and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module tb_kmeans_lloyd_clusterer;

  class kmeans_scoreboard;
    logic [3:0]                k_reg;
    logic [2:0]                d_reg;
    logic [7:0]                iter_reg;
    logic [kml_pkg::THR_W-1:0] thr_reg;
    int                        pts[kml_pkg::MAX_POINTS][kml_pkg::MAX_DIM];
    int                        npts;
    bit                        ovf;
    int                        cent[kml_pkg::MAX_CLUSTERS][kml_pkg::MAX_DIM];
    kml_pkg::out_word_t        pending[$];
    int                        errors;

    function new();
      k_reg = 4'd2; d_reg = 3'd4; iter_reg = 8'd101; thr_reg = kml_pkg::THR_W'(7);
      npts = 0; ovf = 0; errors = 0;
      foreach (cent[c, j]) cent[c][j] = 0;
    endfunction

    function void write_reg(kml_pkg::cfg_idx_e idx, logic [kml_pkg::THR_W-1:0] val);
      case (idx)
        kml_pkg::CFG_NUM_CLUSTERS: k_reg = val[3:0];
        kml_pkg::CFG_DIMENSIONS:   d_reg = val[2:0];
        kml_pkg::CFG_MAX_ITER:     iter_reg = val[7:0];
        kml_pkg::CFG_THRESHOLD:    thr_reg = val;
        default: ;
      endcase
    endfunction

    function int used_k();
      if (k_reg < 2) return 2;
      if (k_reg > kml_pkg::MAX_CLUSTERS) return kml_pkg::MAX_CLUSTERS;
      return int'(k_reg);
    endfunction

    function int used_d();
      if (d_reg < 1) return 1;
      if (d_reg > kml_pkg::MAX_DIM) return kml_pkg::MAX_DIM;
      return int'(d_reg);
    endfunction

    function int closest(int p[kml_pkg::MAX_DIM], int k, int d);
      int best;
      longint unsigned bestd, dsq;
      longint df;
      best = 0; bestd = 0;
      for (int c = 0; c < k; c++) begin
        dsq = 0;
        for (int j = 0; j < d; j++) begin
          df = longint'(cent[c][j]) - longint'(p[j]);
          dsq += longint'(df * df);
        end
        if (c == 0 || dsq < bestd) begin
          bestd = dsq;
          best = c;
        end
      end
      return best;
    endfunction

    // note an accepted input word and queue the words it causes
    function void note_word(kml_pkg::in_word_t w);
      int v[kml_pkg::MAX_DIM];
      int k, d, a, passes, limit;
      bit conv;
      longint sums[kml_pkg::MAX_CLUSTERS][kml_pkg::MAX_DIM];
      int cnts[kml_pkg::MAX_CLUSTERS];
      longint unsigned change;
      longint m, df;
      logic [15:0] oc[kml_pkg::MAX_DIM];
      kml_pkg::out_word_t o;
      v[0] = w.coord_0; v[1] = w.coord_1; v[2] = w.coord_2; v[3] = w.coord_3;
      k = used_k(); d = used_d();
      case (w.action)
        kml_pkg::ACT_LOAD_POINT: begin
          if (npts < kml_pkg::MAX_POINTS) begin
            pts[npts] = v;
            npts++;
          end else ovf = 1;
        end
        kml_pkg::ACT_LOAD_CENTROID: begin
          if (w.slot < kml_pkg::MAX_CLUSTERS) cent[w.slot] = v;
        end
        kml_pkg::ACT_CLASSIFY: begin
          o = '0;
          o.kind = kml_pkg::KIND_CLASSIFY;
          o.cluster_index = kml_pkg::CL_W'(closest(v, k, d));
          o.last = 1;
          pending.push_back(o);
        end
        default: begin
          limit = (iter_reg == 0) ? 1 : int'(iter_reg);
          passes = 0; conv = 0;
          forever begin
            change = 0;
            foreach (sums[c, j]) sums[c][j] = 0;
            foreach (cnts[c]) cnts[c] = 0;
            for (int i = 0; i < npts; i++) begin
              a = closest(pts[i], k, d);
              for (int j = 0; j < d; j++) sums[a][j] += pts[i][j];
              cnts[a]++;
            end
            for (int c = 0; c < k; c++) begin
              if (cnts[c] != 0) begin
                for (int j = 0; j < d; j++) begin
                  m = sums[c][j] / longint'(cnts[c]);
                  df = m - longint'(cent[c][j]);
                  change += longint'(df * df);
                  cent[c][j] = int'(m);
                end
              end
            end
            passes++;
            if (change < thr_reg) begin
              conv = 1;
              break;
            end
            if (passes >= limit) break;
          end
          for (int c = 0; c < k; c++) begin
            foreach (oc[j]) oc[j] = (j < d) ? cent[c][j][15:0] : 16'h0;
            o = '0;
            o.kind = kml_pkg::KIND_CENTROID;
            o.cluster_index = kml_pkg::CL_W'(c);
            o.out_coord_0 = oc[0]; o.out_coord_1 = oc[1];
            o.out_coord_2 = oc[2]; o.out_coord_3 = oc[3];
            pending.push_back(o);
          end
          o = '0;
          o.kind = kml_pkg::KIND_STATUS;
          o.converged = conv;
          o.passes_done = passes[7:0];
          o.points_dropped = ovf;
          o.last = 1;
          pending.push_back(o);
        end
      endcase
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_word(kml_pkg::out_word_t a);
      kml_pkg::out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("kind", e.kind, a.kind);
      cmp("cluster_index", e.cluster_index, a.cluster_index);
      cmp("out_coord_0", e.out_coord_0, a.out_coord_0);
      cmp("out_coord_1", e.out_coord_1, a.out_coord_1);
      cmp("out_coord_2", e.out_coord_2, a.out_coord_2);
      cmp("out_coord_3", e.out_coord_3, a.out_coord_3);
      cmp("converged", e.converged, a.converged);
      cmp("passes_done", e.passes_done, a.passes_done);
      cmp("points_dropped", e.points_dropped, a.points_dropped);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  localparam int WATCHDOG_CYCLES = 2000000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  kml_pkg::in_word_t           in_data_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  kml_pkg::out_word_t          out_data_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [kml_pkg::CFG_AW-1:0]  cfg_index_i;
  logic [kml_pkg::THR_W-1:0]   cfg_data_i;

  kmeans_scoreboard sb;
  bit in_fast, out_fast;
  bit hold_req;
  int centers[4][kml_pkg::MAX_DIM];
  int idle_cycles;

  kmeans_lloyd_clusterer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // receiver: random gaps per word, plus one long hold on request
  initial begin
    int gap, hold_left;
    gap = 0; hold_left = 0;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 0;
      end else if (out_valid_o && out_ready_i) begin
        gap = out_fast ? 0 : $urandom_range(0, 9);
        out_ready_i <= (gap == 0);
      end else if (gap > 0) begin
        gap--;
        out_ready_i <= (gap == 0);
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid is left high after a word so the next word can follow back to back
  task automatic send(kml_pkg::in_word_t w);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(kml_pkg::cfg_idx_e idx, logic [kml_pkg::THR_W-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [3:0] k, logic [2:0] d, logic [7:0] it,
                         logic [kml_pkg::THR_W-1:0] thr);
    write_cfg(kml_pkg::CFG_NUM_CLUSTERS, kml_pkg::THR_W'(k));
    write_cfg(kml_pkg::CFG_DIMENSIONS, kml_pkg::THR_W'(d));
    write_cfg(kml_pkg::CFG_MAX_ITER, kml_pkg::THR_W'(it));
    write_cfg(kml_pkg::CFG_THRESHOLD, thr);
  endtask

  function automatic kml_pkg::in_word_t mk(kml_pkg::action_e a, int c0, int c1,
                                           int c2, int c3, int s);
    kml_pkg::in_word_t w;
    w.action = a;
    w.coord_0 = c0[15:0]; w.coord_1 = c1[15:0];
    w.coord_2 = c2[15:0]; w.coord_3 = c3[15:0];
    w.slot = s[2:0];
    return w;
  endfunction

  // mostly points near a few centers, sometimes anything at all
  function automatic kml_pkg::in_word_t rand_word(kml_pkg::action_e a);
    kml_pkg::in_word_t w;
    int c, v[kml_pkg::MAX_DIM];
    c = $urandom_range(0, 3);
    foreach (v[j]) begin
      if ($urandom_range(0, 4) == 0) v[j] = $urandom;
      else v[j] = centers[c][j] + $urandom_range(0, 1200) - 600;
    end
    w = mk(a, v[0], v[1], v[2], v[3], $urandom_range(0, 7));
    return w;
  endfunction

  task automatic random_phase(int n, bit with_hold);
    int r;
    foreach (centers[c, j]) centers[c][j] = $urandom_range(0, 40000) - 20000;
    in_fast  = ($urandom_range(0, 3) == 0);
    out_fast = ($urandom_range(0, 3) == 0);
    if (with_hold) hold_req = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 28)      send(rand_word(kml_pkg::ACT_LOAD_POINT));
      else if (r < 52) send(rand_word(kml_pkg::ACT_LOAD_CENTROID));
      else if (r < 96) send(rand_word(kml_pkg::ACT_CLASSIFY));
      else             send(rand_word(kml_pkg::ACT_TRAIN));
    end
    send(rand_word(kml_pkg::ACT_TRAIN));
    drain();
    in_fast = 0; out_fast = 0;
  endtask

  initial begin
    logic [kml_pkg::THR_W-1:0] thr;
    in_valid_i = 0; in_data_i = '0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    hold_req = 0; in_fast = 0; out_fast = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // reset settings: empty store, zero centroids, extremes
    send(mk(kml_pkg::ACT_TRAIN, 0, 0, 0, 0, 0));
    send(mk(kml_pkg::ACT_CLASSIFY, 5, -5, 7, 0, 0));
    send(mk(kml_pkg::ACT_LOAD_CENTROID, -32768, -32768, -32768, -32768, 0));
    send(mk(kml_pkg::ACT_LOAD_CENTROID, 32767, 32767, 32767, 32767, 1));
    send(mk(kml_pkg::ACT_LOAD_CENTROID, 100, 100, 100, 100, 7));
    send(mk(kml_pkg::ACT_CLASSIFY, 32767, 32767, 32767, 32767, 0));
    send(mk(kml_pkg::ACT_CLASSIFY, -32768, -32768, -32768, -32768, 0));
    send(mk(kml_pkg::ACT_CLASSIFY, 0, 0, 0, 0, 7));
    send(mk(kml_pkg::ACT_LOAD_POINT, -32768, 32767, -32768, 32767, 0));
    send(mk(kml_pkg::ACT_LOAD_POINT, 32767, -32768, 32767, -32768, 0));
    send(mk(kml_pkg::ACT_LOAD_POINT, -300, 200, -1, 1, 0));
    send(mk(kml_pkg::ACT_LOAD_POINT, 500, -700, 3, -3, 0));
    send(mk(kml_pkg::ACT_TRAIN, 0, 0, 0, 0, 0));
    drain();

    // out-of-range counts and dims clamp, zero pass limit, zero threshold
    set_all(4'd1, 3'd0, 8'd0, '0);
    send(mk(kml_pkg::ACT_TRAIN, 0, 0, 0, 0, 0));
    send(mk(kml_pkg::ACT_CLASSIFY, 1, 2, 3, 4, 0));
    drain();
    set_all(4'd15, 3'd7, 8'd255, '0);
    send(mk(kml_pkg::ACT_LOAD_CENTROID, 10, 20, 30, 40, 3));
    send(mk(kml_pkg::ACT_TRAIN, 0, 0, 0, 0, 0));
    drain();
    set_all(4'd0, 3'd5, 8'd3, {kml_pkg::THR_W{1'b1}});
    send(mk(kml_pkg::ACT_TRAIN, 0, 0, 0, 0, 0));
    send(mk(kml_pkg::ACT_CLASSIFY, -32768, 32767, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 2))
        0: thr = '0;
        1: thr = kml_pkg::THR_W'($urandom_range(0, 5000));
        default: thr = kml_pkg::THR_W'({$urandom, $urandom});
      endcase
      set_all((p == 0) ? 4'd8 : 4'($urandom_range(2, 8)),
              (p == 0) ? 3'd4 : 3'($urandom_range(1, 4)),
              8'($urandom_range(1, 4)), thr);
      random_phase(68, p == 2);
    end

    // fill the store past capacity
    set_all(4'd2, 3'd1, 8'd1, 36'd100);
    in_fast = 1;
    while (sb.npts < kml_pkg::MAX_POINTS) send(rand_word(kml_pkg::ACT_LOAD_POINT));
    in_fast = 0;
    repeat (3) send(rand_word(kml_pkg::ACT_LOAD_POINT));
    send(rand_word(kml_pkg::ACT_CLASSIFY));
    send(rand_word(kml_pkg::ACT_TRAIN));
    drain();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
